>>> src/sstf_pkg.sv
// Shared types, constants and helpers of the SSTF disk request scheduler.
`default_nettype none

package sstf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int CYL_BITS    = 16;
   localparam int TIME_BITS   = 32;
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      OUT_SERVED   = 3'd0,
      OUT_IDLE     = 3'd1,
      OUT_LOADED   = 3'd2,
      OUT_FULL     = 3'd3,
      OUT_CLEARED  = 3'd4
   } outcome_type;

   // Record that travels down the cell row during one scan.
   typedef struct packed {
      logic                active;
      logic                is_load;
      logic                hit;
      logic [CYL_BITS-1:0] seek;
      logic [CYL_BITS-1:0] cyl;
      logic [IDX_BITS-1:0] idx;
   } rec_type;

   // Values the controller presents to every cell at once.
   typedef struct packed {
      logic [CYL_BITS-1:0]  head;
      logic [TIME_BITS-1:0] sim_time;
      logic [TIME_BITS-1:0] load_arrival;
      logic [CYL_BITS-1:0]  load_cyl;
      logic                 clear_all;
      logic                 free_strobe;
      logic [IDX_BITS-1:0]  free_idx;
   } bus_type;

   function automatic logic [TIME_BITS-1:0] time_add_sat(
      input logic [TIME_BITS-1:0] t,
      input logic [TIME_BITS-1:0] d
   );
      logic [TIME_BITS:0] s;
      s = {1'b0, t} + {1'b0, d};
      return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/sstf_cell.sv
// One table slot of the scheduler row, with its stage of the scan record.
`default_nettype none

module sstf_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [sstf_pkg::IDX_BITS-1:0]    cell_idx,
   input  wire  sstf_pkg::bus_type          bus,
   input  wire  sstf_pkg::rec_type          up_rec,
   output sstf_pkg::rec_type                down_rec
);
   import sstf_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] arrival_ff;
   logic [CYL_BITS-1:0]  cyl_ff;
   rec_type              rec_ff, rec_in;

   logic                 eligible, take, place;
   logic [CYL_BITS-1:0]  seek;

   always_comb begin
      eligible = valid_ff && (arrival_ff <= bus.sim_time);
      seek     = (cyl_ff >= bus.head) ? (cyl_ff - bus.head) : (bus.head - cyl_ff);
      take     = up_rec.active && !up_rec.is_load && eligible &&
                 (!up_rec.hit || (seek < up_rec.seek));
      place    = up_rec.active && up_rec.is_load && !valid_ff && !up_rec.hit;

      rec_in = up_rec;
      if (take) begin
         rec_in.hit  = 1'b1;
         rec_in.seek = seek;
         rec_in.cyl  = cyl_ff;
         rec_in.idx  = cell_idx;
      end else if (place) begin
         rec_in.hit = 1'b1;
         rec_in.idx = cell_idx;
      end

      valid_in = valid_ff;
      if (bus.clear_all) begin
         valid_in = 1'b0;
      end else if (bus.free_strobe && (bus.free_idx == cell_idx)) begin
         valid_in = 1'b0;
      end else if (place) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         rec_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rec_ff   <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (place) begin
         arrival_ff <= bus.load_arrival;
         cyl_ff     <= bus.load_cyl;
      end
   end

   assign down_rec = rec_ff;

endmodule

`default_nettype wire

>>> src/sstf_ctrl.sv
// Command sequencer, scheduler state and result register of the scheduler.
`default_nettype none

module sstf_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [1:0]                       req_cmd,
   input  wire  [31:0]                      req_arrival_time,
   input  wire  [15:0]                      req_cylinder,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [2:0]                       rsp_outcome,
   output logic [15:0]                      rsp_served_cylinder,
   output logic [15:0]                      rsp_seek_distance,
   output logic [31:0]                      rsp_current_time,
   output logic [8:0]                       rsp_pending_left,
   input  wire                              csr_write_enable,
   input  wire  [15:0]                      csr_write_data,
   output sstf_pkg::rec_type                head_rec,
   input  wire  sstf_pkg::rec_type          tail_rec,
   output sstf_pkg::bus_type                bus
);
   import sstf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [TIME_BITS-1:0] arrival_ff;
   logic [CYL_BITS-1:0]  cyl_ff;
   logic                 inject_ff;
   rec_type              result_ff;

   logic [CYL_BITS-1:0]  head_ff, head_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 started_ff, started_in;
   logic [15:0]          start_head_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           outcome_ff, outcome_in;
   logic [15:0]          served_ff, served_in;
   logic [15:0]          seek_ff, seek_in;

   logic                 accept, finish_fire, table_full, clear_all, free_strobe;
   logic                 start_scan;
   cmd_type              req_cmd_t;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_cmd_t   = cmd_type'(req_cmd);
   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign table_full  = (count_ff >= CNT_BITS'(TABLE_DEPTH));
   assign start_scan  = accept && (req_cmd_t == CMD_STEP ||
                                   (req_cmd_t == CMD_LOAD && !table_full));

   always_comb begin
      head_in     = head_ff;
      time_in     = time_ff;
      count_in    = count_ff;
      started_in  = started_ff;
      outcome_in  = OUT_IDLE;
      served_in   = '0;
      seek_in     = '0;
      clear_all   = 1'b0;
      free_strobe = 1'b0;
      case (cmd_ff)
         CMD_LOAD: begin
            if (table_full) begin
               outcome_in = OUT_FULL;
            end else begin
               outcome_in = OUT_LOADED;
               count_in   = count_ff + CNT_BITS'(1);
               if (!started_ff) begin
                  time_in    = arrival_ff;
                  started_in = 1'b1;
               end
            end
         end
         CMD_STEP: begin
            if (result_ff.hit) begin
               outcome_in  = OUT_SERVED;
               served_in   = 16'(result_ff.cyl);
               seek_in     = (32'(result_ff.seek) > 32'hFFFF) ? 16'hFFFF
                                                             : 16'(result_ff.seek);
               time_in     = time_add_sat(time_ff, TIME_BITS'(result_ff.seek));
               head_in     = result_ff.cyl;
               count_in    = count_ff - CNT_BITS'(1);
               free_strobe = finish_fire;
            end else begin
               outcome_in = OUT_IDLE;
               time_in    = time_add_sat(time_ff, TIME_BITS'(1));
            end
         end
         CMD_CLEAR: begin
            outcome_in = OUT_CLEARED;
            count_in   = '0;
            time_in    = '0;
            started_in = 1'b0;
            head_in    = CYL_BITS'(start_head_ff);
            clear_all  = finish_fire;
         end
         default: begin
            outcome_in = OUT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inject_ff     <= 1'b0;
         head_ff       <= '0;
         time_ff       <= '0;
         count_ff      <= '0;
         started_ff    <= 1'b0;
         start_head_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         inject_ff <= start_scan;
         if (csr_write_enable) begin
            start_head_ff <= csr_write_data;
         end
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start_scan) begin
                  state_ff <= ST_SCAN;
               end else if (accept &&
                            (req_cmd_t == CMD_LOAD || req_cmd_t == CMD_CLEAR)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (tail_rec.active) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (finish_fire) begin
                  head_ff    <= head_in;
                  time_ff    <= time_in;
                  count_ff   <= count_in;
                  started_ff <= started_in;
                  outcome_ff <= outcome_in;
                  served_ff  <= served_in;
                  seek_ff    <= seek_in;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_cmd_t;
         arrival_ff <= req_arrival_time;
         cyl_ff     <= CYL_BITS'(req_cylinder);
      end
      if (state_ff == ST_SCAN && tail_rec.active) begin
         result_ff <= tail_rec;
      end
   end

   always_comb begin
      head_rec         = '0;
      head_rec.active  = inject_ff;
      head_rec.is_load = (cmd_ff == CMD_LOAD);

      bus.head         = head_ff;
      bus.sim_time     = time_ff;
      bus.load_arrival = arrival_ff;
      bus.load_cyl     = cyl_ff;
      bus.clear_all    = clear_all;
      bus.free_strobe  = free_strobe;
      bus.free_idx     = result_ff.idx;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_served_cylinder = served_ff;
   assign rsp_seek_distance   = seek_ff;
   assign rsp_current_time    = time_ff;
   assign rsp_pending_left    = 9'(count_ff);

endmodule

`default_nettype wire

>>> src/sstf_disk_request_scheduler_top.sv
// Top level of the SSTF disk request scheduler: controller and the row of slot cells.
//
//   Channel   Ports   Direction   Beat
//   request   req_*   in          cmd, arrival_time, cylinder
//   response  rsp_*   out         outcome, served_cylinder, seek_distance,
//                                 current_time, pending_left
//   config    csr_*   in          start_head, written when csr_write_enable is high
//
// A step, and a load into a table that is not full, send one record down the row of
// TABLE_DEPTH cells, one cell per cycle, before the response is registered; a clear or
// a rejected load goes straight to the final update without a scan.
// The next request beat is accepted once the previous response is registered.
// Reset empties every slot and zeroes head, time and count; a stalled response holds
// only the final update of the following beat.
`default_nettype none

module sstf_disk_request_scheduler_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [1:0]   req_cmd,
   input  wire  [31:0]  req_arrival_time,
   input  wire  [15:0]  req_cylinder,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [2:0]   rsp_outcome,
   output logic [15:0]  rsp_served_cylinder,
   output logic [15:0]  rsp_seek_distance,
   output logic [31:0]  rsp_current_time,
   output logic [8:0]   rsp_pending_left,
   input  wire          csr_write_enable,
   input  wire  [15:0]  csr_write_data
);
   import sstf_pkg::*;

   rec_type chain [TABLE_DEPTH+1];
   bus_type bus;

   sstf_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_arrival_time    (req_arrival_time),
      .req_cylinder        (req_cylinder),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_outcome         (rsp_outcome),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_seek_distance   (rsp_seek_distance),
      .rsp_current_time    (rsp_current_time),
      .rsp_pending_left    (rsp_pending_left),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .head_rec            (chain[0]),
      .tail_rec            (chain[TABLE_DEPTH]),
      .bus                 (bus)
   );

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      sstf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(k)),
         .bus      (bus),
         .up_rec   (chain[k]),
         .down_rec (chain[k+1])
      );
   end

endmodule

`default_nettype wire
